/* rtl/mcte_pkg.sv */
// ----------------------------------------------------------------------------
// mcte_pkg
// Shared constants and types for the MIDI clock tempo estimator.
// ----------------------------------------------------------------------------
package mcte_pkg;

    localparam int WINDOW_DEPTH_DEF = 12;
    localparam int FRAC_BITS_DEF    = 8;

    localparam int STATUS_W = 8;
    localparam int STAMP_W  = 32;
    localparam int TICK_W   = 32;
    localparam int TEMPO_W  = 20;

    localparam logic [STATUS_W-1:0] STATUS_CLOCK = 8'd248;
    localparam logic [STATUS_W-1:0] STATUS_START = 8'd250;
    localparam logic [STATUS_W-1:0] STATUS_STOP  = 8'd252;

    localparam int SEC_PER_MIN     = 60;
    localparam int MS_PER_SEC      = 1000;
    localparam int PULSES_PER_BEAT = 24;
    localparam int MS_PER_PULSE    = SEC_PER_MIN * MS_PER_SEC / PULSES_PER_BEAT;

    localparam logic [TEMPO_W-1:0] TEMPO_MAX = '1;

    typedef struct packed {
        logic wr_en;
        logic rd_start;
        logic rd_next;
    } win_ctrl_t;

endpackage

/* rtl/midi_clock_tempo_estimator_top.sv */
// Flow: a clock item stores its stamp, then for each interval in the window divides
//   the scaled pulse period by the gap and sums the quotients, then divides the sum
//   by the interval count; start and other items are taken without an output item.
// Throughput: one item at a time, set by the bit-serial divider (one bit per cycle).
// Reset: window pointers, fill, tick counter and handshakes cleared; stamps undefined.
// ----------------------------------------------------------------------------
// midi_clock_tempo_estimator_top
// Tempo from MIDI clock timestamps: averaged per-interval BPM in Q.FRAC_BITS.
// ----------------------------------------------------------------------------
module midi_clock_tempo_estimator_top #(
    parameter int WINDOW_DEPTH = mcte_pkg::WINDOW_DEPTH_DEF,
    parameter int FRAC_BITS    = mcte_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mcte_pkg::STATUS_W-1:0] s_status_byte,
    input  logic [mcte_pkg::STAMP_W-1:0]  s_time_ms,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mcte_pkg::TEMPO_W-1:0]  m_tempo_bpm_q8,
    output logic                          m_tempo_valid,
    output logic [mcte_pkg::TICK_W-1:0]   m_tick_count
);
    import mcte_pkg::*;

    localparam longint unsigned NUMER_VAL = longint'(MS_PER_PULSE) << FRAC_BITS;
    localparam int NUM_W  = $clog2(NUMER_VAL + 1);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH);
    localparam int SUM_W  = NUM_W + CNT_W;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam logic [SUM_W-1:0] NUMER = SUM_W'(NUMER_VAL);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_PREV  = 3'd2;
    localparam logic [2:0] S_GAP   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_AVG   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [TICK_W-1:0]  ticks_reg, ticks_next;
    logic [STAMP_W-1:0] prev_reg, prev_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic [TEMPO_W-1:0] res_tempo_reg, res_tempo_next;
    logic               res_valid_reg, res_valid_next;
    logic               m_valid_reg, m_valid_next;
    logic [TEMPO_W-1:0] m_tempo_reg;
    logic               m_tvalid_reg;
    logic [TICK_W-1:0]  m_tick_reg;

    win_ctrl_t          win_ctrl;
    logic [STAMP_W-1:0] win_rd_data;
    logic [FILL_W-1:0]  win_fill;
    logic [FILL_W-1:0]  fill_m1;
    logic [STAMP_W-1:0] gap;

    logic               div_start;
    logic [SUM_W-1:0]   div_dividend;
    logic [STAMP_W-1:0] div_divisor;
    logic [SUM_W-1:0]   div_quo;
    logic               div_busy;
    logic               div_done;
    logic [63:0]        avg_ext;
    logic               in_fire;
    logic               out_free;

    mcte_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .FILL_W       (FILL_W)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (win_ctrl),
        .wr_data (s_time_ms),
        .rd_data (win_rd_data),
        .fill    (win_fill)
    );

    mcte_div #(
        .DVD_W (SUM_W),
        .DVS_W (STAMP_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .busy     (div_busy),
        .done     (div_done)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign fill_m1  = win_fill - FILL_W'(1);
    assign gap      = win_rd_data - prev_reg;
    assign avg_ext  = 64'(div_quo);

    always_comb begin
        state_next     = state_reg;
        ticks_next     = ticks_reg;
        prev_next      = prev_reg;
        sum_next       = sum_reg;
        left_next      = left_reg;
        res_tempo_next = res_tempo_reg;
        res_valid_next = res_valid_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        win_ctrl       = '0;
        div_start      = 1'b0;
        div_dividend   = NUMER;
        div_divisor    = gap;

        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    case (s_status_byte)
                        STATUS_CLOCK: begin
                            ticks_next     = ticks_reg + TICK_W'(1);
                            win_ctrl.wr_en = 1'b1;
                            state_next     = S_SETUP;
                        end
                        STATUS_START: begin
                            ticks_next = '0;
                        end
                        STATUS_STOP: begin
                            ticks_next = ticks_reg;
                        end
                        default: begin
                            ticks_next = ticks_reg;
                        end
                    endcase
                end
            end
            S_SETUP: begin
                res_tempo_next = '0;
                res_valid_next = 1'b0;
                sum_next       = '0;
                left_next      = fill_m1[CNT_W-1:0];
                if (win_fill < FILL_W'(2)) begin
                    state_next = S_DONE;
                end else begin
                    win_ctrl.rd_start = 1'b1;
                    state_next        = S_PREV;
                end
            end
            S_PREV: begin
                prev_next        = win_rd_data;
                win_ctrl.rd_next = 1'b1;
                state_next       = S_GAP;
            end
            S_GAP: begin
                prev_next = win_rd_data;
                if (gap == '0) begin
                    state_next = S_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    sum_next  = sum_reg + div_quo;
                    left_next = left_reg - CNT_W'(1);
                    if (left_reg == CNT_W'(1)) begin
                        div_start    = 1'b1;
                        div_dividend = sum_reg + div_quo;
                        div_divisor  = STAMP_W'(fill_m1);
                        state_next   = S_AVG;
                    end else begin
                        win_ctrl.rd_next = 1'b1;
                        state_next       = S_GAP;
                    end
                end
            end
            S_AVG: begin
                if (div_done) begin
                    res_valid_next = 1'b1;
                    if (avg_ext > 64'(TEMPO_MAX)) begin
                        res_tempo_next = TEMPO_MAX;
                    end else begin
                        res_tempo_next = avg_ext[TEMPO_W-1:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ticks_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ticks_reg   <= ticks_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg      <= prev_next;
        sum_reg       <= sum_next;
        left_reg      <= left_next;
        res_tempo_reg <= res_tempo_next;
        res_valid_reg <= res_valid_next;
        if (state_reg == S_DONE && out_free) begin
            m_tempo_reg  <= res_tempo_reg;
            m_tvalid_reg <= res_valid_reg;
            m_tick_reg   <= ticks_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_tempo_bpm_q8 = m_tempo_reg;
    assign m_tempo_valid  = m_tvalid_reg;
    assign m_tick_count   = m_tick_reg;

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_tempo_valid |-> m_tempo_bpm_q8 == '0)
        else $error("invalid tempo item carries nonzero tempo");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> (state_reg == S_DIV || state_reg == S_AVG))
        else $error("divider running outside a divide state");

    a_tick_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_status_byte == STATUS_CLOCK |=> ticks_reg == $past(ticks_reg) + TICK_W'(1))
        else $error("tick counter did not advance on clock item");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        win_fill <= FILL_W'(WINDOW_DEPTH))
        else $error("window fill beyond depth");

endmodule

/* rtl/mcte_window.sv */
// ----------------------------------------------------------------------------
// mcte_window
// Circular stamp window: write at head, read oldest to newest one per cycle in which rd_start or rd_next is set.
// ----------------------------------------------------------------------------
module mcte_window #(
    parameter int WINDOW_DEPTH = mcte_pkg::WINDOW_DEPTH_DEF,
    parameter int FILL_W       = $clog2(WINDOW_DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mcte_pkg::win_ctrl_t           ctrl,
    input  logic [mcte_pkg::STAMP_W-1:0]  wr_data,
    output logic [mcte_pkg::STAMP_W-1:0]  rd_data,
    output logic [FILL_W-1:0]             fill
);
    import mcte_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int PTR_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);

    logic [STAMP_W-1:0] mem [WINDOW_DEPTH];
    logic [STAMP_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [IDX_W-1:0]   rd_addr;
    logic [PTR_W-1:0]   head_ext, fill_ext, oldest_ext;
    logic [IDX_W-1:0]   oldest;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
        if (p == LAST_IDX) begin
            return '0;
        end
        return p + IDX_W'(1);
    endfunction

    assign head_ext = PTR_W'(head_reg);
    assign fill_ext = PTR_W'(fill_reg);

    always_comb begin
        if (head_ext >= fill_ext) begin
            oldest_ext = head_ext - fill_ext;
        end else begin
            oldest_ext = head_ext + PTR_W'(WINDOW_DEPTH) - fill_ext;
        end
    end
    assign oldest = oldest_ext[IDX_W-1:0];

    always_comb begin
        head_next   = head_reg;
        fill_next   = fill_reg;
        rd_ptr_next = rd_ptr_reg;
        rd_addr     = rd_ptr_reg;
        if (ctrl.wr_en) begin
            head_next = wrap_inc(head_reg);
            if (fill_reg < FILL_W'(WINDOW_DEPTH)) begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
        if (ctrl.rd_start) begin
            rd_addr     = oldest;
            rd_ptr_next = wrap_inc(oldest);
        end else if (ctrl.rd_next) begin
            rd_ptr_next = wrap_inc(rd_ptr_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            fill_reg   <= '0;
            rd_ptr_reg <= '0;
        end else begin
            head_reg   <= head_next;
            fill_reg   <= fill_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[head_reg] <= wr_data;
        end
        if (ctrl.rd_start || ctrl.rd_next) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign fill    = fill_reg;

endmodule

/* rtl/mcte_div.sv */
// ----------------------------------------------------------------------------
// mcte_div
// Bit-serial restoring divider, one quotient bit per cycle while busy.
// ----------------------------------------------------------------------------
module mcte_div #(
    parameter int DVD_W = 25,
    parameter int DVS_W = mcte_pkg::STAMP_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output logic             busy,
    output logic             done
);
    import mcte_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dq_reg, dq_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, dq_reg[DVD_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dq_next   = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            dq_next  = {dq_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = dq_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule
